// ----- design/servo_report_frame_parser_top_assert.svh -----
// Assertion macros for the servo report frame parser.
`ifndef SERVO_REPORT_FRAME_PARSER_TOP_ASSERT_SVH
`define SERVO_REPORT_FRAME_PARSER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRFP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/srfp_pkg.sv -----
// Constants and widths for the servo report frame parser.
package srfp_pkg;

	localparam int FRAME_BYTES = 64;

	localparam logic [7:0] HDR_BYTE = 8'h55;
	localparam logic [7:0] CMD_RUN  = 8'h06;
	localparam logic [7:0] CMD_STOP = 8'h07;
	localparam logic [7:0] CMD_DONE = 8'h08;
	localparam logic [7:0] CMD_BATT = 8'h0F;

	localparam int EV_INVALID   = 0;
	localparam int EV_STARTED   = 1;
	localparam int EV_STOPPED   = 2;
	localparam int EV_COMPLETED = 3;
	localparam int EV_BATTERY   = 4;
	localparam int EV_W         = 5;

	localparam logic OP_FEED = 1'b0;
	localparam logic OP_TAKE = 1'b1;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 56;

	typedef logic [EV_W-1:0] events_t;

endpackage

// ----- design/servo_report_frame_parser_top.sv -----
// Servo report frame parser: input register, byte decode, result register.
// An accepted item is held in the input register and its result in the result register.
// Throughput: one item per cycle while results are taken; a held result register stalls the input.
// The header, length and parameter decode is one pass between those registers.
// Reset clears the frame hunt, the pending events and the report values at once.
module servo_report_frame_parser_top #(
	parameter int FRAME_BYTES = srfp_pkg::FRAME_BYTES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [srfp_pkg::IN_DATA_W-1:0]    s_tdata,  // [7:0] rx_byte
	input  logic                              s_tuser,  // [0] operation
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [4:0] event_bits, [12:5] last_command, [20:13] run_group,
	// [36:21] loop_total, [52:37] supply_mv, [55:53] zero
	output logic [srfp_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tlast   // frame_done
);

	localparam int CW = $clog2(FRAME_BYTES + 1);
	localparam logic [CW-1:0] CNT_HUNT = CW'(0);
	localparam logic [CW-1:0] CNT_HDR1 = CW'(1);
	localparam logic [CW-1:0] CNT_LEN  = CW'(2);
	localparam logic [CW-1:0] CNT_CMD  = CW'(3);
	localparam logic [CW-1:0] CNT_PAR0 = CW'(4);

	// Input register.
	logic                         valid_s1;
	logic                         op_s1;
	logic [7:0]                   byte_s1;

	// Parser state.
	logic [CW-1:0]                byte_count_q, byte_count_n;
	logic [7:0]                   frame_length_q, frame_length_n;
	logic [7:0]                   frame_command_q, frame_command_n;
	logic [2:0][7:0]              param_bytes_q, param_bytes_n;
	srfp_pkg::events_t            pending_events_q, pending_events_n;
	logic [7:0]                   report_command_q, report_command_n;
	logic [7:0]                   report_group_q, report_group_n;
	logic [15:0]                  report_repeat_q, report_repeat_n;
	logic [15:0]                  report_mv_q, report_mv_n;

	srfp_pkg::events_t            ev_set;
	srfp_pkg::events_t            ev_out;
	logic                         done_c;
	logic                         bad_len;
	logic [CW-1:0]                cnt_inc;
	logic                         advance;

	// Result register.
	logic                         valid_q;
	logic [srfp_pkg::OUT_DATA_W-1:0] data_q;
	logic                         done_q;

	assign advance  = valid_s1 && (!valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	assign bad_len = (byte_s1 < 8'd2) || ({1'b0, byte_s1} > 9'(FRAME_BYTES - 2));
	assign cnt_inc = byte_count_q + CW'(1);

	always_comb begin
		byte_count_n     = byte_count_q;
		frame_length_n   = frame_length_q;
		frame_command_n  = frame_command_q;
		param_bytes_n    = param_bytes_q;
		report_command_n = report_command_q;
		report_group_n   = report_group_q;
		report_repeat_n  = report_repeat_q;
		report_mv_n      = report_mv_q;
		ev_set           = '0;
		done_c           = 1'b0;
		if (op_s1 == srfp_pkg::OP_FEED) begin
			if (byte_count_q == CNT_HUNT) begin
				if (byte_s1 == srfp_pkg::HDR_BYTE) begin
					byte_count_n = CNT_HDR1;
				end
			end else if (byte_count_q == CNT_HDR1) begin
				byte_count_n = (byte_s1 == srfp_pkg::HDR_BYTE) ? CNT_LEN : CNT_HUNT;
			end else if (byte_count_q == CNT_LEN) begin
				if (bad_len) begin
					ev_set[srfp_pkg::EV_INVALID] = 1'b1;
					// A bad length that is itself a header byte counts as the first header.
					byte_count_n = (byte_s1 == srfp_pkg::HDR_BYTE) ? CNT_HDR1 : CNT_HUNT;
				end else begin
					frame_length_n = byte_s1;
					byte_count_n   = CNT_CMD;
				end
			end else begin
				if (byte_count_q == CNT_CMD) begin
					frame_command_n = byte_s1;
				end
				for (int i = 0; i < 3; i++) begin
					if (byte_count_q == CNT_PAR0 + CW'(i)) begin
						param_bytes_n[i] = byte_s1;
					end
				end
				if (10'(cnt_inc) == 10'(frame_length_q) + 10'd2) begin
					done_c           = 1'b1;
					byte_count_n     = CNT_HUNT;
					report_command_n = frame_command_n;
					case (frame_command_n)
						srfp_pkg::CMD_RUN, srfp_pkg::CMD_DONE: begin
							if (frame_length_q == 8'd5) begin
								report_group_n  = param_bytes_n[0];
								report_repeat_n = {param_bytes_n[2], param_bytes_n[1]};
								if (frame_command_n == srfp_pkg::CMD_RUN) begin
									ev_set[srfp_pkg::EV_STARTED] = 1'b1;
								end else begin
									ev_set[srfp_pkg::EV_COMPLETED] = 1'b1;
								end
							end else begin
								ev_set[srfp_pkg::EV_INVALID] = 1'b1;
							end
						end
						srfp_pkg::CMD_STOP: begin
							if (frame_length_q == 8'd2) begin
								ev_set[srfp_pkg::EV_STOPPED] = 1'b1;
							end else begin
								ev_set[srfp_pkg::EV_INVALID] = 1'b1;
							end
						end
						srfp_pkg::CMD_BATT: begin
							if (frame_length_q == 8'd4) begin
								report_mv_n = {param_bytes_n[1], param_bytes_n[0]};
								ev_set[srfp_pkg::EV_BATTERY] = 1'b1;
							end else begin
								ev_set[srfp_pkg::EV_INVALID] = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end else begin
					byte_count_n = cnt_inc;
				end
			end
			pending_events_n = pending_events_q | ev_set;
			ev_out           = pending_events_n;
		end else begin
			// A take reports what was pending and then clears it.
			pending_events_n = '0;
			ev_out           = pending_events_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q     <= CNT_HUNT;
			pending_events_q <= '0;
			report_command_q <= '0;
			report_group_q   <= '0;
			report_repeat_q  <= '0;
			report_mv_q      <= '0;
		end else if (advance) begin
			byte_count_q     <= byte_count_n;
			pending_events_q <= pending_events_n;
			report_command_q <= report_command_n;
			report_group_q   <= report_group_n;
			report_repeat_q  <= report_repeat_n;
			report_mv_q      <= report_mv_n;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			frame_length_q  <= frame_length_n;
			frame_command_q <= frame_command_n;
			param_bytes_q   <= param_bytes_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_q <= {3'b000, report_mv_n, report_repeat_n, report_group_n,
				report_command_n, ev_out};
			done_q <= done_c;
		end
	end

	`include "servo_report_frame_parser_top_assert.svh"

	`SRFP_ASSERT_NEXT(a_take_clears, advance && (op_s1 == srfp_pkg::OP_TAKE), pending_events_q == '0, "take did not clear pending events")
	`SRFP_ASSERT_NEXT(a_done_rehunt, advance && done_c, byte_count_q == CNT_HUNT, "parser did not return to hunting after a frame")
	`SRFP_ASSERT_NOW(a_count_range, 1'b1, 10'(byte_count_q) < 10'(FRAME_BYTES), "byte count beyond frame store")

endmodule

// ----- tb/servo_report_frame_parser_top_test.sv -----
// Self-checking testbench for the servo report frame parser with random stream stalls.
module servo_report_frame_parser_top_test;
	import srfp_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int RANDOM_ITEMS = 950;

	typedef struct packed {
		events_t     ev;
		logic [7:0]  cmd;
		logic [7:0]  group;
		logic [15:0] rep_count;
		logic [15:0] mv;
		logic        done;
	} report_t;

	class servo_report_tracker;
		int          hunt_count;
		logic [7:0]  frame_len;
		logic [7:0]  frame_cmd;
		logic [7:0]  params [3];
		events_t     pending;
		logic [7:0]  rep_cmd;
		logic [7:0]  rep_group;
		logic [15:0] rep_count;
		logic [15:0] rep_mv;
		report_t     expected_reports [$];
		int          errors;

		function new();
			hunt_count = 0;
			frame_len = '0;
			frame_cmd = '0;
			foreach (params[i]) params[i] = '0;
			pending = '0;
			rep_cmd = '0;
			rep_group = '0;
			rep_count = '0;
			rep_mv = '0;
			errors = 0;
		endfunction

		function void close_frame();
			rep_cmd = frame_cmd;
			if (frame_cmd == CMD_RUN || frame_cmd == CMD_DONE) begin
				if (frame_len == 8'd5) begin
					rep_group = params[0];
					rep_count = {params[2], params[1]};
					if (frame_cmd == CMD_RUN) pending[EV_STARTED] = 1'b1;
					else pending[EV_COMPLETED] = 1'b1;
				end else begin
					pending[EV_INVALID] = 1'b1;
				end
			end else if (frame_cmd == CMD_STOP) begin
				if (frame_len == 8'd2) pending[EV_STOPPED] = 1'b1;
				else pending[EV_INVALID] = 1'b1;
			end else if (frame_cmd == CMD_BATT) begin
				if (frame_len == 8'd4) begin
					rep_mv = {params[1], params[0]};
					pending[EV_BATTERY] = 1'b1;
				end else begin
					pending[EV_INVALID] = 1'b1;
				end
			end
		endfunction

		// Returns 1 when the byte closes a frame.
		function logic feed(logic [7:0] b);
			if (hunt_count == 0) begin
				if (b == HDR_BYTE) hunt_count = 1;
				return 1'b0;
			end
			if (hunt_count == 1) begin
				hunt_count = (b == HDR_BYTE) ? 2 : 0;
				return 1'b0;
			end
			if (hunt_count == 2) begin
				if (b < 8'd2 || int'(b) + 2 > FRAME_BYTES) begin
					pending[EV_INVALID] = 1'b1;
					// A bad length byte that looks like a header byte counts as the first header byte.
					hunt_count = (b == HDR_BYTE) ? 1 : 0;
					return 1'b0;
				end
				frame_len = b;
			end else if (hunt_count == 3) begin
				frame_cmd = b;
			end else if (hunt_count >= 4 && hunt_count <= 6) begin
				params[hunt_count - 4] = b;
			end
			hunt_count++;
			if (hunt_count == int'(frame_len) + 2) begin
				close_frame();
				hunt_count = 0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_item(logic op, logic [7:0] b);
			report_t r;
			r.done = 1'b0;
			if (op == OP_FEED) begin
				r.done = feed(b);
				r.ev = pending;
			end else begin
				r.ev = pending;
				pending = '0;
			end
			r.cmd = rep_cmd;
			r.group = rep_group;
			r.rep_count = rep_count;
			r.mv = rep_mv;
			expected_reports.push_back(r);
		endfunction

		function void compare(string name, logic [15:0] exp_val, logic [15:0] act_val);
			if (exp_val !== act_val) begin
				$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val,
					act_val);
				errors++;
			end
		endfunction

		function void check_report(logic [OUT_DATA_W-1:0] data, logic done);
			report_t r;
			if (expected_reports.size() == 0) begin
				$display("%0t: result with nothing expected: expected none, actual %h/%b",
					$time, data, done);
				errors++;
				return;
			end
			r = expected_reports.pop_front();
			compare("event_bits", 16'(r.ev), 16'(data[4:0]));
			compare("last_command", 16'(r.cmd), 16'(data[12:5]));
			compare("run_group", 16'(r.group), 16'(data[20:13]));
			compare("loop_total", r.rep_count, data[36:21]);
			compare("supply_mv", r.mv, data[52:37]);
			compare("frame_done", 16'(r.done), 16'(done));
		endfunction

		function int outstanding();
			return expected_reports.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	servo_report_tracker tracker;
	int sent;
	int received;
	int idle_cycles;

	servo_report_frame_parser_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic send_item(logic op, logic [7:0] b);
		int gap;
		gap = ((sent >= 250 && sent < 350) || (sent >= 700 && sent < 760)) ? 0
			: $urandom_range(0, 3);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = b;
		s_tuser = op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.note_item(op, b);
		sent++;
	endtask

	task automatic send_byte(logic [7:0] b);
		send_item(OP_FEED, b);
	endtask

	task automatic send_frame(logic [7:0] len, logic [7:0] cmd);
		send_byte(HDR_BYTE);
		send_byte(HDR_BYTE);
		send_byte(len);
		send_byte(cmd);
		for (int i = 2; i < int'(len); i++) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic send_random_frame();
		logic [7:0] cmd;
		int good_len;
		int len;
		case ($urandom_range(0, 4))
			0: begin cmd = CMD_RUN;  good_len = 5; end
			1: begin cmd = CMD_STOP; good_len = 2; end
			2: begin cmd = CMD_DONE; good_len = 5; end
			3: begin cmd = CMD_BATT; good_len = 4; end
			default: begin
				cmd = 8'($urandom_range(0, 255));
				good_len = $urandom_range(2, 8);
			end
		endcase
		len = good_len;
		if ($urandom_range(0, 9) == 0) begin
			// Mostly short wrong lengths; now and then a long frame up to the store size.
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(2, FRAME_BYTES - 2)
				: $urandom_range(2, 8);
		end
		send_frame(8'(len), cmd);
	endtask

	task automatic send_bad_length();
		logic [7:0] len;
		case ($urandom_range(0, 3))
			0: len = 8'($urandom_range(0, 1));
			1: len = HDR_BYTE;
			2: len = 8'($urandom_range(FRAME_BYTES - 1, 255));
			default: len = 8'($urandom_range(0, 255));
		endcase
		send_byte(HDR_BYTE);
		send_byte(HDR_BYTE);
		send_byte(len);
	endtask

	// Receiver: random holds between results, a burst with none, and one long hold-off.
	initial begin
		int hold;
		forever begin
			hold = (received >= 450 && received < 550) ? 0 : $urandom_range(0, 3);
			if (received == 300) hold = 150;
			repeat (hold) begin
				@(negedge clk);
				m_tready = 1'b0;
			end
			@(negedge clk);
			m_tready = 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			tracker.check_report(m_tdata, m_tlast);
			received++;
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int pick;
		tracker = new();
		sent = 0;
		received = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_FEED;
		m_tready = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed part.
		send_item(OP_TAKE, 8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(HDR_BYTE);
		send_byte(8'hAA);
		send_byte(HDR_BYTE);
		send_byte(HDR_BYTE);
		send_byte(8'h01);
		// A length byte equal to the header byte counts as the first header byte.
		send_byte(HDR_BYTE);
		send_byte(HDR_BYTE);
		send_byte(HDR_BYTE);
		send_byte(HDR_BYTE);
		send_byte(8'h02);
		send_byte(CMD_STOP);
		send_byte(HDR_BYTE);
		send_byte(HDR_BYTE);
		send_byte(8'(FRAME_BYTES - 1));
		send_byte(HDR_BYTE);
		send_byte(HDR_BYTE);
		send_byte(8'h05);
		send_byte(CMD_RUN);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_item(OP_TAKE, 8'h00);

		// Random part: mostly whole frames, with noise, takes and broken headers mixed in.
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) send_random_frame();
			else if (pick < 80) send_item(OP_TAKE, 8'($urandom_range(0, 255)));
			else if (pick < 88) send_byte(8'($urandom_range(0, 255)));
			else if (pick < 94) send_bad_length();
			else begin
				send_byte(HDR_BYTE);
				send_byte(8'($urandom_range(0, 255)));
			end
		end
		@(negedge clk);
		s_tvalid = 1'b0;

		while (tracker.outstanding() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
